// ===== hw/rtl/lvm_pkg.sv =====
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared widths, types and stage counts for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int AXIS_W    = FRAC_BITS + 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int VEC_W     = 64;
  localparam int MAG_W     = 62;
  localparam int NRM_W     = 30;
  localparam int SQ_W      = 2 * NRM_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int NUM_W     = NRM_W + FRAC_BITS + 1;
  localparam int RSTEPS    = 6;
  localparam int LSTEPS    = 5;
  localparam int NRM_ST    = 2 + RSTEPS + LSTEPS + 2 + ROOT_W + 1 + (FRAC_BITS + 1) + 1;
  localparam int X1_W      = CRD_W + AXIS_W;
  localparam int X2_W      = 2 * AXIS_W;
  localparam int PRD_W     = AXIS_W + CRD_W;
  localparam int DOT_W     = PRD_W + 2;

  typedef logic signed [VEC_W-1:0]  comp_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic [2:0][CRD_W-1:0]  eye;
    logic [2:0][CRD_W-1:0]  upr;
    logic [2:0][AXIS_W-1:0] z;
    logic [2:0][AXIS_W-1:0] x;
    logic [2:0][AXIS_W-1:0] y;
  } side_t;

  typedef struct packed {
    logic       vld;
    logic       ok;
    logic [2:0] neg;
    side_t      side;
  } nrm_ctl_t;

endpackage

// ===== hw/rtl/lvm_norm.sv =====
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined vector normalizer: block scaling, squares, bit-per-stage square
// root and one restoring division per component, rounded to nearest.
// ----------------------------------------------------------------------------
module lvm_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lvm_pkg::nrm_ctl_t ctl_i,
  input  lvm_pkg::comp_t    vec_i [3],
  output lvm_pkg::nrm_ctl_t ctl_o,
  output lvm_pkg::axis_t    axis_o [3]
);
  import lvm_pkg::*;

  localparam logic [MAG_W-1:0] LO_LIM = MAG_W'(1) << (NRM_W - 1);

  nrm_ctl_t ctl_r   [NRM_ST];
  nrm_ctl_t ctl_nxt [NRM_ST];

  comp_t            abs_c [3];
  logic [2:0]       neg_c;
  logic [MAG_W-1:0] mag_c [3];
  logic [MAG_W-1:0] mag_r [3];
  logic [MAG_W-1:0] top_c;

  logic [MAG_W-1:0] rm_r [RSTEPS+1][3];
  logic [MAG_W-1:0] rt_r [RSTEPS+1];
  logic [NRM_W-1:0] lm_r [LSTEPS][3];
  logic [NRM_W-1:0] lt_r [LSTEPS];

  logic [SQ_W-1:0]  sq_r [3];
  logic [NRM_W-1:0] mq_r [3];

  logic [SUM_W-1:0] sn_r [ROOT_W+1];
  logic [SUM_W-1:0] sr_r [ROOT_W+1];
  logic [NRM_W-1:0] sm_r [ROOT_W+1][3];

  logic [ROOT_W-1:0] root_c;
  logic [NUM_W-1:0]  rem_r [FRAC_BITS+2][3];
  logic [QUO_W-1:0]  q_r   [FRAC_BITS+2][3];
  logic [ROOT_W-1:0] dl_r  [FRAC_BITS+2];
  axis_t             axis_r [3];

  // control chain, valid travels with data
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = vec_i[i][VEC_W-1];
      abs_c[i] = neg_c[i] ? -vec_i[i] : vec_i[i];
      mag_c[i] = abs_c[i][MAG_W-1:0];
    end
    top_c = mag_r[0];
    if (mag_r[1] > top_c) top_c = mag_r[1];
    if (mag_r[2] > top_c) top_c = mag_r[2];
    ctl_nxt[0]     = ctl_i;
    ctl_nxt[0].neg = neg_c;
    for (int k = 1; k < NRM_ST; k++) ctl_nxt[k] = ctl_r[k-1];
    ctl_nxt[1].ok = ctl_r[0].ok & (top_c != '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NRM_ST; k++) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else if (en) begin
        ctl_r[k] <= ctl_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_c;
      rm_r[0] <= mag_r;
      rt_r[0] <= top_c;
    end
  end

  // scale down until the largest magnitude is below 2^30
  for (genvar g = 0; g < RSTEPS; g++) begin : g_rsh
    localparam int SH = (1 << (RSTEPS - 1)) >> g;
    logic take;
    assign take = (rt_r[g] >> SH) >= LO_LIM;
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[g+1] <= take ? rt_r[g] >> SH : rt_r[g];
        for (int i = 0; i < 3; i++) rm_r[g+1][i] <= take ? rm_r[g][i] >> SH : rm_r[g][i];
      end
    end
  end

  // scale up until the largest magnitude reaches 2^29
  for (genvar g = 0; g < LSTEPS; g++) begin : g_lsh
    localparam int SH = (1 << (LSTEPS - 1)) >> g;
    logic [NRM_W-1:0] sm [3];
    logic [NRM_W-1:0] st;
    logic             take;
    if (g == 0) begin : g_src0
      assign st = rt_r[RSTEPS][NRM_W-1:0];
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign sm[i] = rm_r[RSTEPS][i][NRM_W-1:0];
      end
    end else begin : g_srcn
      assign st = lt_r[g-1];
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign sm[i] = lm_r[g-1][i];
      end
    end
    assign take = (st >> (NRM_W - SH)) == '0;
    always_ff @(posedge clk) begin
      if (en) begin
        lt_r[g] <= take ? st << SH : st;
        for (int i = 0; i < 3; i++) lm_r[g][i] <= take ? sm[i] << SH : sm[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(lm_r[LSTEPS-1][i]) * SQ_W'(lm_r[LSTEPS-1][i]);
        mq_r[i] <= lm_r[LSTEPS-1][i];
      end
      sn_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      sr_r[0] <= '0;
      sm_r[0] <= mq_r;
    end
  end

  // floor square root, one result bit per stage
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - g));
    logic [SUM_W-1:0] trial;
    assign trial = sr_r[g] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sn_r[g] >= trial) begin
          sn_r[g+1] <= sn_r[g] - trial;
          sr_r[g+1] <= (sr_r[g] >> 1) + BIT;
        end else begin
          sn_r[g+1] <= sn_r[g];
          sr_r[g+1] <= sr_r[g] >> 1;
        end
        sm_r[g+1] <= sm_r[g];
      end
    end
  end

  assign root_c = sr_r[ROOT_W][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (NUM_W'(sm_r[ROOT_W][i]) << FRAC_BITS) + NUM_W'(root_c >> 1);
        q_r[0][i]   <= '0;
      end
      dl_r[0] <= root_c;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_div
    localparam int J = FRAC_BITS - g;
    logic [NUM_W-1:0] dv;
    assign dv = NUM_W'(dl_r[g]) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_r[g][i] >= dv) begin
            rem_r[g+1][i] <= rem_r[g][i] - dv;
            q_r[g+1][i]   <= q_r[g][i] | (QUO_W'(1) << J);
          end else begin
            rem_r[g+1][i] <= rem_r[g][i];
            q_r[g+1][i]   <= q_r[g][i];
          end
        end
        dl_r[g+1] <= dl_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!ctl_r[NRM_ST-2].ok) begin
          axis_r[i] <= '0;
        end else if (ctl_r[NRM_ST-2].neg[i]) begin
          axis_r[i] <= -$signed({1'b0, q_r[FRAC_BITS+1][i]});
        end else begin
          axis_r[i] <= $signed({1'b0, q_r[FRAC_BITS+1][i]});
        end
      end
    end
  end

  assign ctl_o  = ctl_r[NRM_ST-1];
  assign axis_o = axis_r;

endmodule

// ===== hw/rtl/lookat_view_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// lookat_view_matrix_unit
// Look-at view matrix: back, right and up axes with their offsets, Q16.16.
// ----------------------------------------------------------------------------
//  channel  handshake          beat
//  in_      in_valid/in_stall  eye, aim, up reference (9 x 32 bit)
//  out_     out_valid/out_stall three rows: 3 axis terms (18 bit) + offset (32 bit)
//
//  One beat per cycle in and out while out_stall does not hold the output.
//  Data passes through three chained normalizers, each a 31-stage square
//  root and a 17-stage divider.
//  Reset clears the valid bits only. A stalled full output freezes the
//  whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module lookat_view_matrix_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_eye_x,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_eye_y,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_eye_z,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_aim_x,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_aim_y,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_aim_z,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_upref_x,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_upref_y,
  input  logic signed [lvm_pkg::CRD_W-1:0]  in_upref_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_right_x,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_right_y,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_right_z,
  output logic signed [lvm_pkg::CRD_W-1:0]  out_right_offset,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_upaxis_x,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_upaxis_y,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_upaxis_z,
  output logic signed [lvm_pkg::CRD_W-1:0]  out_upaxis_offset,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_back_x,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_back_y,
  output logic signed [lvm_pkg::AXIS_W-1:0] out_back_z,
  output logic signed [lvm_pkg::CRD_W-1:0]  out_back_offset
);
  import lvm_pkg::*;

  localparam logic [DOT_W-1:0] HALF    = DOT_W'(1) << (FRAC_BITS - 1);
  localparam logic [DOT_W-1:0] POS_MAX = (DOT_W'(1) << (CRD_W - 1)) - DOT_W'(1);
  localparam logic [DOT_W-1:0] NEG_MAX = DOT_W'(1) << (CRD_W - 1);

  logic en;

  nrm_ctl_t ctl0_r, ctl0_nxt;
  comp_t    d_r [3];

  nrm_ctl_t c1, c2, c3;
  axis_t    z_o [3], x_o [3], y_o [3];

  nrm_ctl_t              c1a_r, c1b_r, c2a_r, c2b_r;
  nrm_ctl_t              c1a_nxt, c2a_nxt, o1_nxt;
  logic signed [X1_W-1:0] p1_r [6];
  logic signed [X2_W-1:0] p2_r [6];
  comp_t                  t1_r [3], t2_r [3];

  nrm_ctl_t                o1_r, o2_r, o3_r;
  logic signed [PRD_W-1:0] pr_r  [3][3];
  logic signed [DOT_W-1:0] dot_r [3];
  logic [DOT_W-1:0]        dmag_c [3];
  logic [DOT_W-1:0]        rnd_r  [3];
  logic [2:0]              sg_r;

  logic                    out_valid_r;
  axis_t                   ax_r  [3][3];
  logic signed [CRD_W-1:0] ofs_r [3];
  logic signed [CRD_W-1:0] ofs_c [3];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    ctl0_nxt             = '0;
    ctl0_nxt.vld         = in_valid;
    ctl0_nxt.ok          = 1'b1;
    ctl0_nxt.side.eye[0] = in_eye_x;
    ctl0_nxt.side.eye[1] = in_eye_y;
    ctl0_nxt.side.eye[2] = in_eye_z;
    ctl0_nxt.side.upr[0] = in_upref_x;
    ctl0_nxt.side.upr[1] = in_upref_y;
    ctl0_nxt.side.upr[2] = in_upref_z;
  end

  always_comb begin
    c1a_nxt        = c1;
    c1a_nxt.side.z = {z_o[2], z_o[1], z_o[0]};
    c2a_nxt        = c2;
    c2a_nxt.side.x = {x_o[2], x_o[1], x_o[0]};
    o1_nxt         = c3;
    o1_nxt.side.y  = {y_o[2], y_o[1], y_o[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.vld <= 1'b0;
      c1a_r.vld  <= 1'b0;
      c1b_r.vld  <= 1'b0;
      c2a_r.vld  <= 1'b0;
      c2b_r.vld  <= 1'b0;
      o1_r.vld   <= 1'b0;
      o2_r.vld   <= 1'b0;
      o3_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl0_r      <= ctl0_nxt;
      c1a_r       <= c1a_nxt;
      c1b_r       <= c1a_r;
      c2a_r       <= c2a_nxt;
      c2b_r       <= c2a_r;
      o1_r        <= o1_nxt;
      o2_r        <= o1_r;
      o3_r        <= o2_r;
      out_valid_r <= o3_r.vld;
    end
  end

  // back axis input
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= VEC_W'(in_eye_x) - VEC_W'(in_aim_x);
      d_r[1] <= VEC_W'(in_eye_y) - VEC_W'(in_aim_y);
      d_r[2] <= VEC_W'(in_eye_z) - VEC_W'(in_aim_z);
    end
  end

  lvm_norm u_norm_z (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(ctl0_r), .vec_i(d_r), .ctl_o(c1), .axis_o(z_o)
  );

  // right axis: cross(upref, z)
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= $signed(c1.side.upr[1]) * z_o[2];
      p1_r[1] <= $signed(c1.side.upr[2]) * z_o[1];
      p1_r[2] <= $signed(c1.side.upr[2]) * z_o[0];
      p1_r[3] <= $signed(c1.side.upr[0]) * z_o[2];
      p1_r[4] <= $signed(c1.side.upr[0]) * z_o[1];
      p1_r[5] <= $signed(c1.side.upr[1]) * z_o[0];
      for (int i = 0; i < 3; i++) t1_r[i] <= VEC_W'(p1_r[2*i]) - VEC_W'(p1_r[2*i+1]);
    end
  end

  lvm_norm u_norm_x (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(c1b_r), .vec_i(t1_r), .ctl_o(c2), .axis_o(x_o)
  );

  // up axis: cross(z, x)
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r[0] <= $signed(c2.side.z[1]) * x_o[2];
      p2_r[1] <= $signed(c2.side.z[2]) * x_o[1];
      p2_r[2] <= $signed(c2.side.z[2]) * x_o[0];
      p2_r[3] <= $signed(c2.side.z[0]) * x_o[2];
      p2_r[4] <= $signed(c2.side.z[0]) * x_o[1];
      p2_r[5] <= $signed(c2.side.z[1]) * x_o[0];
      for (int i = 0; i < 3; i++) t2_r[i] <= VEC_W'(p2_r[2*i]) - VEC_W'(p2_r[2*i+1]);
    end
  end

  lvm_norm u_norm_y (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(c2b_r), .vec_i(t2_r), .ctl_o(c3), .axis_o(y_o)
  );

  // offsets: -round(dot(axis, eye))
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dmag_c[r] = dot_r[r][DOT_W-1] ? DOT_W'(-dot_r[r]) : DOT_W'(dot_r[r]);
      if (sg_r[r]) begin
        ofs_c[r] = (rnd_r[r] > POS_MAX) ? POS_MAX[CRD_W-1:0] : rnd_r[r][CRD_W-1:0];
      end else begin
        ofs_c[r] = (rnd_r[r] > NEG_MAX) ? NEG_MAX[CRD_W-1:0] : -rnd_r[r][CRD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[0][i] <= $signed(o1_nxt.side.x[i]) * $signed(o1_nxt.side.eye[i]);
        pr_r[1][i] <= $signed(o1_nxt.side.y[i]) * $signed(o1_nxt.side.eye[i]);
        pr_r[2][i] <= $signed(o1_nxt.side.z[i]) * $signed(o1_nxt.side.eye[i]);
      end
      for (int r = 0; r < 3; r++) begin
        dot_r[r] <= DOT_W'(pr_r[r][0]) + DOT_W'(pr_r[r][1]) + DOT_W'(pr_r[r][2]);
        rnd_r[r] <= (dmag_c[r] + HALF) >> FRAC_BITS;
        sg_r[r]  <= dot_r[r][DOT_W-1];
      end
      for (int i = 0; i < 3; i++) begin
        ax_r[0][i] <= o3_r.ok ? $signed(o3_r.side.x[i]) : '0;
        ax_r[1][i] <= o3_r.ok ? $signed(o3_r.side.y[i]) : '0;
        ax_r[2][i] <= o3_r.ok ? $signed(o3_r.side.z[i]) : '0;
      end
      for (int r = 0; r < 3; r++) ofs_r[r] <= o3_r.ok ? ofs_c[r] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_right_x       = ax_r[0][0];
  assign out_right_y       = ax_r[0][1];
  assign out_right_z       = ax_r[0][2];
  assign out_right_offset  = ofs_r[0];
  assign out_upaxis_x      = ax_r[1][0];
  assign out_upaxis_y      = ax_r[1][1];
  assign out_upaxis_z      = ax_r[1][2];
  assign out_upaxis_offset = ofs_r[1];
  assign out_back_x        = ax_r[2][0];
  assign out_back_y        = ax_r[2][1];
  assign out_back_z        = ax_r[2][2];
  assign out_back_offset   = ofs_r[2];

endmodule
